FILE: sv/b64c_pkg.sv
`timescale 1ns / 1ps

package b64c_pkg;

    localparam logic       MODE_ENCODE    = 1'b0;
    localparam logic       MODE_DECODE    = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_LENGTH  = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [7:0] PAD_CHAR       = 8'h3D;

    // most results one item can cause
    localparam int         BURST_MAX      = 4;

    typedef struct packed
    {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       has_data;
        logic       out_last;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed
    {
        logic [23:0] group_store;
        logic [1:0]  group_position;
        logic        padding_seen;
        logic        invalid_seen;
    } codec_state_t;

    typedef struct packed
    {
        logic [2:0]                      count;
        out_item_t [BURST_MAX-1:0]       items;
    } burst_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] char_encode(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
                return 8'(w + 8'd65);
            else if (v < 6'd52)
                return 8'(w + 8'd71);
            else if (v < 6'd62)
                return 8'(w - 8'd4);
            else if (v == 6'd62)
                return 8'h2B;
            else
                return 8'h2F;
        end
    endfunction

    // character to {invalid, value}; a non-alphabet character reads as 63
    function automatic logic [6:0] char_decode(input logic [7:0] c);
        begin
            if (c >= 8'h41 && c <= 8'h5A)
                return {1'b0, 6'(c - 8'h41)};
            else if (c >= 8'h61 && c <= 8'h7A)
                return {1'b0, 6'(c - 8'd71)};
            else if (c >= 8'h30 && c <= 8'h39)
                return {1'b0, 6'(c + 8'd4)};
            else if (c == 8'h2B)
                return {1'b0, 6'd62};
            else if (c == 8'h2F)
                return {1'b0, 6'd63};
            else
                return {1'b1, 6'd63};
        end
    endfunction

    function automatic out_item_t data_item(input logic [7:0] b, input logic last);
        out_item_t r;
        begin
            r.out_byte = b;
            r.has_data = 1'b1;
            r.out_last = last;
            r.status   = STATUS_OK;
            return r;
        end
    endfunction

endpackage

FILE: sv/b64c_step.sv
`timescale 1ns / 1ps

module b64c_step
(
    input  logic                    mode,
    input  b64c_pkg::codec_state_t  st,
    input  b64c_pkg::in_item_t      item,
    output b64c_pkg::codec_state_t  st_next,
    output b64c_pkg::burst_t        burst
);

    logic [7:0]            b;
    logic [6:0]            dec;
    logic [5:0]            v;
    logic [1:0]            pos_inc;
    logic                  n_data;
    logic [1:0]            end_status;
    b64c_pkg::out_item_t   marker;

    assign b       = item.in_byte;
    assign dec     = b64c_pkg::char_decode(b);
    assign v       = dec[5:0];
    assign pos_inc = st.group_position + 2'd1;

    always_comb
    begin
        st_next    = st;
        burst      = '0;
        n_data     = 1'b0;
        end_status = b64c_pkg::STATUS_OK;
        marker     = '0;
        if (mode == b64c_pkg::MODE_DECODE)
        begin
            if (!st.padding_seen)
            begin
                if (st.group_position[1] && b == b64c_pkg::PAD_CHAR)
                begin
                    st_next.padding_seen = 1'b1;
                end
                else
                begin
                    if (dec[6])
                        st_next.invalid_seen = 1'b1;
                    case (st.group_position)
                        2'd0:
                        begin
                            st_next.group_store = {v, 18'b0};
                        end
                        2'd1:
                        begin
                            st_next.group_store = st.group_store | {6'b0, v, 12'b0};
                            burst.items[0] = b64c_pkg::data_item(
                                {st.group_store[23:18], v[5:4]}, 1'b0);
                            n_data = 1'b1;
                        end
                        2'd2:
                        begin
                            st_next.group_store = st.group_store | {12'b0, v, 6'b0};
                            burst.items[0] = b64c_pkg::data_item(
                                {st.group_store[15:12], v[5:2]}, 1'b0);
                            n_data = 1'b1;
                        end
                        default:
                        begin
                            st_next.group_store = '0;
                            burst.items[0] = b64c_pkg::data_item(
                                {st.group_store[7:6], v}, 1'b0);
                            n_data = 1'b1;
                        end
                    endcase
                end
            end
            st_next.group_position = pos_inc;
            if (item.in_last)
            begin
                // length error wins over a bad character
                if (pos_inc != 2'd0)
                    end_status = b64c_pkg::STATUS_LENGTH;
                else if (st_next.invalid_seen)
                    end_status = b64c_pkg::STATUS_INVALID;
                marker.out_last = 1'b1;
                marker.status   = end_status;
                if (n_data)
                    burst.items[1] = marker;
                else
                    burst.items[0] = marker;
                burst.count = 3'(n_data) + 3'd1;
                st_next     = '0;
            end
            else
            begin
                burst.count = 3'(n_data);
            end
        end
        else
        begin
            case (st.group_position)
                2'd0:
                begin
                    st_next.group_store    = {b, 16'b0};
                    st_next.group_position = 2'd1;
                    burst.items[0] = b64c_pkg::data_item(
                        b64c_pkg::char_encode(b[7:2]), 1'b0);
                    if (item.in_last)
                    begin
                        burst.items[1] = b64c_pkg::data_item(
                            b64c_pkg::char_encode({b[1:0], 4'b0}), 1'b0);
                        burst.items[2] = b64c_pkg::data_item(b64c_pkg::PAD_CHAR, 1'b0);
                        burst.items[3] = b64c_pkg::data_item(b64c_pkg::PAD_CHAR, 1'b1);
                        burst.count    = 3'd4;
                    end
                    else
                    begin
                        burst.count = 3'd1;
                    end
                end
                2'd1:
                begin
                    st_next.group_store    = {st.group_store[23:16], b, 8'b0};
                    st_next.group_position = 2'd2;
                    burst.items[0] = b64c_pkg::data_item(
                        b64c_pkg::char_encode({st.group_store[17:16], b[7:4]}), 1'b0);
                    if (item.in_last)
                    begin
                        burst.items[1] = b64c_pkg::data_item(
                            b64c_pkg::char_encode({b[3:0], 2'b0}), 1'b0);
                        burst.items[2] = b64c_pkg::data_item(b64c_pkg::PAD_CHAR, 1'b1);
                        burst.count    = 3'd3;
                    end
                    else
                    begin
                        burst.count = 3'd1;
                    end
                end
                default:
                begin
                    st_next.group_store    = '0;
                    st_next.group_position = 2'd0;
                    burst.items[0] = b64c_pkg::data_item(
                        b64c_pkg::char_encode({st.group_store[11:8], b[7:6]}), 1'b0);
                    burst.items[1] = b64c_pkg::data_item(
                        b64c_pkg::char_encode(b[5:0]), item.in_last);
                    burst.count    = 3'd2;
                end
            endcase
            if (item.in_last)
                st_next = '0;
        end
    end

endmodule

FILE: sv/b64c_burst.sv
`timescale 1ns / 1ps

module b64c_burst
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_ready,
    input  b64c_pkg::burst_t      load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b64c_pkg::out_item_t   out_data
);

    b64c_pkg::out_item_t [b64c_pkg::BURST_MAX-1:0] items_reg;
    logic [2:0] left_reg;
    logic [2:0] left_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_fire;
    logic       load_fire;

    assign out_valid  = (left_reg != 3'd0);
    assign out_data   = items_reg[idx_reg];
    assign out_fire   = out_valid && out_ready;
    // a new burst may land as the last pending result transfers
    assign load_ready = (left_reg == 3'd0) || (left_reg == 3'd1 && out_ready);
    assign load_fire  = load_valid && load_ready;

    always_comb
    begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (load_fire)
        begin
            left_next = load.count;
            idx_next  = 2'd0;
        end
        else if (out_fire)
        begin
            left_next = left_reg - 3'd1;
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 3'd0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
            items_reg <= load.items;
    end

`ifndef SYNTHESIS
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'd4)
        else $error("pending result count out of range");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({2'b00, idx_reg} + {1'b0, left_reg}) <= 4'd4)
        else $error("result index runs past the burst");

    a_load_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |-> (left_reg == 3'd0 || (left_reg == 3'd1 && out_fire)))
        else $error("burst overwritten while results pending");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> (idx_reg == 2'd0 && left_reg == $past(load.count)))
        else $error("burst load did not restart the drain");
`endif

endmodule

FILE: sv/base64_codec_core.sv
`timescale 1ns / 1ps

// Streaming Base64 (standard alphabet) encoder/decoder. cfg_data selects encode (0) or
// decode (1); writing it abandons any message in progress, so write it between messages.
// Encode turns each three raw bytes into four characters and pads the final group with
// '='; decode turns each four characters into three bytes, stops at a padded group and
// closes every message with a bare end result (has_data 0) whose status reports a length
// that is not a multiple of four or a non-alphabet character. Each input transfer is
// decoded combinationally into a burst of zero to four results that leave through a single
// registered output, one per cycle while out_ready is high, and the next item is taken
// in the same cycle its predecessor's last result transfers. The block is ready right
// after reset.
module base64_codec_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b64c_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b64c_pkg::out_item_t   out_data
);

    logic                    mode_reg;
    b64c_pkg::codec_state_t  state_reg;
    b64c_pkg::codec_state_t  state_next;
    b64c_pkg::burst_t        burst;
    logic                    cfg_fire;
    logic                    in_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    b64c_step u_step
    (
        .mode    (mode_reg),
        .st      (state_reg),
        .item    (in_data),
        .st_next (state_next),
        .burst   (burst)
    );

    b64c_burst u_burst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid),
        .load_ready (in_ready),
        .load       (burst),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= b64c_pkg::MODE_ENCODE;
            state_reg <= '0;
        end
        else if (cfg_fire)
        begin
            mode_reg  <= cfg_data;
            state_reg <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.in_last) |=>
            (state_reg.group_position == 2'd0 && !state_reg.padding_seen
             && !state_reg.invalid_seen))
        else $error("message state survived the final transfer");

    a_encode_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == b64c_pkg::MODE_ENCODE) |->
            (!state_reg.padding_seen && !state_reg.invalid_seen))
        else $error("decode flags set in encode mode");

    a_encode_never_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode_reg == b64c_pkg::MODE_ENCODE) |-> (burst.count != 3'd0))
        else $error("encoded byte produced no character");

    a_decode_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode_reg == b64c_pkg::MODE_DECODE && in_data.in_last)
            |-> (burst.count != 3'd0))
        else $error("decoded message without end result");
`endif

endmodule

FILE: test/base64_codec_core_tb.sv
`timescale 1ns / 1ps

module base64_codec_core_tb;

    localparam int NOT_IN_ALPHABET = 64;

    class codec_scoreboard;
        logic                  decode_mode = b64c_pkg::MODE_ENCODE;
        logic [23:0]           group_bits = '0;
        logic [1:0]            group_pos = '0;
        bit                    pad_hit = 1'b0;
        bit                    bad_char = 1'b0;
        b64c_pkg::out_item_t   awaited_results[$];
        int                    mismatches = 0;
        int                    inputs_seen = 0;
        int                    results_seen = 0;

        function void clear_group();
            group_bits = '0;
            group_pos  = '0;
            pad_hit    = 1'b0;
            bad_char   = 1'b0;
        endfunction

        function void set_mode(logic m);
            decode_mode = m;
            clear_group();
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function logic [7:0] sextet_char(logic [5:0] v);
            logic [7:0] w;
            w = {2'b00, v};
            if (v < 6'd26)
                return w + "A";
            if (v < 6'd52)
                return w - 8'd26 + "a";
            if (v < 6'd62)
                return w - 8'd52 + "0";
            return (v == 6'd62) ? "+" : "/";
        endfunction

        function int char_sextet(logic [7:0] c);
            if (c >= "A" && c <= "Z")
                return int'(c - "A");
            if (c >= "a" && c <= "z")
                return int'(c - "a") + 26;
            if (c >= "0" && c <= "9")
                return int'(c - "0") + 52;
            if (c == "+")
                return 62;
            if (c == "/")
                return 63;
            return NOT_IN_ALPHABET;
        endfunction

        function void add_result(logic [7:0] b, logic has, logic last, logic [1:0] st);
            b64c_pkg::out_item_t r;
            r.out_byte = b;
            r.has_data = has;
            r.out_last = last;
            r.status   = st;
            awaited_results = {awaited_results, r};
        endfunction

        function void encode_step(logic [7:0] b, logic last);
            logic [7:0] prev;
            case (group_pos)
                2'd0:
                begin
                    group_bits = {b, 16'h0000};
                    add_result(sextet_char(b[7:2]), 1'b1, 1'b0, b64c_pkg::STATUS_OK);
                    if (last)
                    begin
                        add_result(sextet_char({b[1:0], 4'h0}), 1'b1, 1'b0,
                                   b64c_pkg::STATUS_OK);
                        add_result(b64c_pkg::PAD_CHAR, 1'b1, 1'b0, b64c_pkg::STATUS_OK);
                        add_result(b64c_pkg::PAD_CHAR, 1'b1, 1'b1, b64c_pkg::STATUS_OK);
                    end
                    group_pos = 2'd1;
                end
                2'd1:
                begin
                    prev = group_bits[23:16];
                    group_bits[15:8] = b;
                    add_result(sextet_char({prev[1:0], b[7:4]}), 1'b1, 1'b0,
                               b64c_pkg::STATUS_OK);
                    if (last)
                    begin
                        add_result(sextet_char({b[3:0], 2'b00}), 1'b1, 1'b0,
                                   b64c_pkg::STATUS_OK);
                        add_result(b64c_pkg::PAD_CHAR, 1'b1, 1'b1, b64c_pkg::STATUS_OK);
                    end
                    group_pos = 2'd2;
                end
                default:
                begin
                    prev = group_bits[15:8];
                    add_result(sextet_char({prev[3:0], b[7:6]}), 1'b1, 1'b0,
                               b64c_pkg::STATUS_OK);
                    add_result(sextet_char(b[5:0]), 1'b1, last, b64c_pkg::STATUS_OK);
                    group_bits = '0;
                    group_pos  = 2'd0;
                end
            endcase
            if (last)
                clear_group();
        endfunction

        function void decode_step(logic [7:0] c, logic last);
            int         v;
            logic [5:0] s;
            logic [1:0] st;
            if (!pad_hit)
            begin
                if (group_pos >= 2'd2 && c == b64c_pkg::PAD_CHAR)
                    pad_hit = 1'b1;
                else
                begin
                    v = char_sextet(c);
                    if (v == NOT_IN_ALPHABET)
                    begin
                        v = 63;
                        bad_char = 1'b1;
                    end
                    s = v[5:0];
                    case (group_pos)
                        2'd0:
                            group_bits = {s, 18'h0};
                        2'd1:
                        begin
                            add_result({group_bits[23:18], s[5:4]}, 1'b1, 1'b0,
                                       b64c_pkg::STATUS_OK);
                            group_bits[17:12] = s;
                        end
                        2'd2:
                        begin
                            add_result({group_bits[15:12], s[5:2]}, 1'b1, 1'b0,
                                       b64c_pkg::STATUS_OK);
                            group_bits[11:6] = s;
                        end
                        default:
                        begin
                            add_result({group_bits[7:6], s}, 1'b1, 1'b0,
                                       b64c_pkg::STATUS_OK);
                            group_bits = '0;
                        end
                    endcase
                end
            end
            group_pos = group_pos + 2'd1;
            if (last)
            begin
                // length error wins over a bad character
                if (group_pos != 2'd0)
                    st = b64c_pkg::STATUS_LENGTH;
                else if (bad_char)
                    st = b64c_pkg::STATUS_INVALID;
                else
                    st = b64c_pkg::STATUS_OK;
                add_result(8'h00, 1'b0, 1'b1, st);
                clear_group();
            end
        endfunction

        function void note_input(b64c_pkg::in_item_t t);
            inputs_seen++;
            if (decode_mode == b64c_pkg::MODE_DECODE)
                decode_step(t.in_byte, t.in_last);
            else
                encode_step(t.in_byte, t.in_last);
        endfunction

        function void check_result(b64c_pkg::out_item_t got);
            b64c_pkg::out_item_t want;
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transfer: out_byte %h has_data %0d %s %0d %s %0d",
                       got.out_byte, got.has_data, "out_last", got.out_last,
                       "status", got.status);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.has_data !== want.has_data)
            begin
                $error("has_data: expected %0d, got %0d", want.has_data, got.has_data);
                mismatches++;
            end
            if (got.out_last !== want.out_last)
            begin
                $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    b64c_pkg::in_item_t    in_data;
    logic                  out_valid;
    logic                  out_ready;
    b64c_pkg::out_item_t   out_data;

    codec_scoreboard sb;
    logic [7:0]      msg_bytes[$];
    logic            cur_mode = b64c_pkg::MODE_ENCODE;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              items_sent = 0;
    int              messages_sent = 0;

    base64_codec_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // every transfer is seen here, on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_mode(cfg_data);
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic add_byte(input logic [7:0] b);
        msg_bytes = {msg_bytes, b};
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_last: last};
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_message(input logic close);
        int n;
        n = msg_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(msg_bytes[i], close && (i == n - 1));
        msg_bytes.delete();
        messages_sent++;
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // sender holds off until every awaited result has transferred
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain_results();
        // a character may still be in flight with no result of its own
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    task automatic run_directed();
        // tails of one, two and three bytes
        add_byte(8'hFF);
        send_message(1'b1);
        add_byte(8'h00);
        add_byte(8'hFF);
        send_message(1'b1);
        add_byte(8'hFC);
        add_byte(8'h0F);
        add_byte(8'hF0);
        send_message(1'b1);
        drain_results();
        // open message cut off by the mode write
        add_byte(8'hAA);
        send_message(1'b0);
        write_mode(b64c_pkg::MODE_DECODE);
        load_text("TWE=");
        send_message(1'b1);
        // pad in third place, fourth character ignored
        load_text("TQ=x");
        send_message(1'b1);
        // pad in first and second place reads as a bad character
        load_text("==/9");
        send_message(1'b1);
        // ignored byte after padding still counts toward length
        load_text("TQ==");
        add_byte(8'hFF);
        send_message(1'b1);
        load_text("A");
        send_message(1'b0);
        write_mode(b64c_pkg::MODE_ENCODE);
    endtask

    task automatic build_encode_message();
        int len;
        len = $urandom_range(9, 1);
        repeat (len)
            add_byte(8'($urandom_range(255)));
    endtask

    task automatic build_decode_message();
        int kind;
        int groups;
        int pad;
        int n;
        kind = $urandom_range(9);
        if (kind >= 8)
        begin
            n = $urandom_range(9, 1);
            repeat (n)
                add_byte(8'($urandom_range(255)));
        end
        else
        begin
            groups = $urandom_range(3, 1);
            repeat (4 * groups)
                add_byte(sb.sextet_char(6'($urandom_range(63))));
            pad = $urandom_range(2);
            n = msg_bytes.size();
            if (pad >= 1)
                msg_bytes[n - 1] = b64c_pkg::PAD_CHAR;
            if (pad == 2)
                msg_bytes[n - 2] = b64c_pkg::PAD_CHAR;
            if (kind == 5 && pad != 0)
                repeat (4)
                    add_byte(8'($urandom_range(255)));
            if (kind == 6)
                msg_bytes[$urandom_range(n - 1)] = 8'($urandom_range(255));
            if (kind == 7)
                void'(msg_bytes.pop_back());
        end
    endtask

    task automatic run_random();
        int target;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            write_mode((phase % 2 == 1) ? b64c_pkg::MODE_DECODE : b64c_pkg::MODE_ENCODE);
            target = items_sent + 20;
            while (items_sent < target)
            begin
                if (cur_mode == b64c_pkg::MODE_DECODE)
                    build_decode_message();
                else
                    build_encode_message();
                send_message($urandom_range(7) != 0);
                if ($urandom_range(9) == 0)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        sb        = new;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = b64c_pkg::MODE_ENCODE;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        run_random();
        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d input transfers in %0d messages, %0d results checked,",
                 sb.inputs_seen, messages_sent, sb.results_seen);
        $display("both modes under four sender idle and receiver stall mixes");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d results still awaited", sb.pending());
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: base64_codec_core.f
sv/b64c_pkg.sv
sv/b64c_step.sv
sv/b64c_burst.sv
sv/base64_codec_core.sv
test/base64_codec_core_tb.sv
